// ===== src/mdc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared widths, register indexes, mode codes and types of the multimode
// digital controller.
// ----------------------------------------------------------------------------
package mdc_pkg;

    // Accumulator width; the derived widths below follow it (32 to 64).
    localparam int ACC_WIDTH  = 40;

    localparam int SAMPLE_W   = 12;
    localparam int ERR_W      = 13;
    localparam int DUTY_W     = 16;
    localparam int GAIN_W     = 18;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Gains are Q1.16; duty is output / 4096 in 1/65536 units.
    localparam int Q_SHIFT    = 16;
    localparam int DUTY_SHIFT = 12;

    // Product and sum widths.
    localparam int PE_W    = ERR_W + GAIN_W;
    localparam int PC_W    = ACC_WIDTH + GAIN_W;
    localparam int PC_Q_W  = PC_W - Q_SHIFT;
    localparam int SUM_W   = PC_Q_W + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OL_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_C    = 3'd5;

    // Control modes.
    localparam logic [MODE_W-1:0] MODE_OPEN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_P    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PI   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMP = 2'd3;

    // Reset values of the registers.
    localparam logic [SAMPLE_W-1:0]      RST_REFERENCE = 12'd2048;
    localparam logic [DUTY_W-1:0]        RST_OL_DUTY   = 16'd32768;
    localparam logic signed [GAIN_W-1:0] RST_GAIN      = 18'sd65536;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [SAMPLE_W-1:0]      reference;
        logic [DUTY_W-1:0]        ol_duty;
        logic signed [GAIN_W-1:0] gain_a;
        logic signed [GAIN_W-1:0] gain_b;
        logic signed [GAIN_W-1:0] pole_c;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0]           duty;
        logic signed [ERR_W-1:0]     error;
        logic                        saturated;
        logic                        state_wr;
        logic signed [ACC_WIDTH-1:0] last_output;
        logic signed [ERR_W-1:0]     last_error;
    } t_law;

endpackage

// ===== src/mdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mdc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module mdc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mdc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output mdc_pkg::t_cfg                   o_cfg
);

    mdc_pkg::t_cfg r_cfg;
    mdc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mdc_pkg::REG_MODE:      n_cfg.mode      = i_cfg_data[mdc_pkg::MODE_W-1:0];
                mdc_pkg::REG_REFERENCE: n_cfg.reference = i_cfg_data[mdc_pkg::SAMPLE_W-1:0];
                mdc_pkg::REG_OL_DUTY:   n_cfg.ol_duty   = i_cfg_data[mdc_pkg::DUTY_W-1:0];
                mdc_pkg::REG_GAIN_A:    n_cfg.gain_a    = i_cfg_data[mdc_pkg::GAIN_W-1:0];
                mdc_pkg::REG_GAIN_B:    n_cfg.gain_b    = i_cfg_data[mdc_pkg::GAIN_W-1:0];
                mdc_pkg::REG_POLE_C:    n_cfg.pole_c    = i_cfg_data[mdc_pkg::GAIN_W-1:0];
                default:                n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= mdc_pkg::MODE_OPEN;
            r_cfg.reference <= mdc_pkg::RST_REFERENCE;
            r_cfg.ol_duty   <= mdc_pkg::RST_OL_DUTY;
            r_cfg.gain_a    <= mdc_pkg::RST_GAIN;
            r_cfg.gain_b    <= mdc_pkg::RST_GAIN;
            r_cfg.pole_c    <= mdc_pkg::RST_GAIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/mdc_law.sv =====
// ----------------------------------------------------------------------------
// mdc_law
// Control law: error, three parallel products, saturating sum and duty clamp.
// ----------------------------------------------------------------------------
module mdc_law (
    input  mdc_pkg::t_cfg                              i_cfg,
    input  logic [mdc_pkg::SAMPLE_W-1:0]               i_sample,
    input  logic                                       i_off,
    input  logic signed [mdc_pkg::ACC_WIDTH-1:0]       i_last_output,
    input  logic signed [mdc_pkg::ERR_W-1:0]           i_last_error,
    output mdc_pkg::t_law                              o_law
);

    localparam int ACC_W = mdc_pkg::ACC_WIDTH;
    localparam int SUM_W = mdc_pkg::SUM_W;
    localparam int PE_W  = mdc_pkg::PE_W;
    localparam int PC_W  = mdc_pkg::PC_W;
    localparam int LO_B  = mdc_pkg::DUTY_SHIFT;
    localparam int HI_B  = mdc_pkg::DUTY_SHIFT + mdc_pkg::DUTY_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [mdc_pkg::DUTY_W-1:0] DUTY_MIN = 16'd1;
    localparam logic [mdc_pkg::DUTY_W-1:0] DUTY_MAX = 16'hFFFF;

    logic signed [mdc_pkg::ERR_W-1:0]  w_err;
    logic signed [PE_W-1:0]            w_pa;
    logic signed [PE_W-1:0]            w_pb;
    logic signed [PC_W-1:0]            w_pc;
    logic signed [mdc_pkg::PC_Q_W-1:0] w_pc_q;
    logic signed [SUM_W-1:0]           w_prev;
    logic signed [SUM_W-1:0]           w_sum;
    logic signed [SUM_W-1:0]           w_sel;
    logic                              w_fits;
    logic signed [ACC_W-1:0]           w_acc;
    logic                              w_small;
    logic                              w_big;

    assign w_err = {1'b0, i_cfg.reference} - {1'b0, i_sample};

    // Products are exact; the pole product is floored from Q.16 back to the
    // accumulator scale by an arithmetic shift.
    assign w_pa   = PE_W'(w_err) * PE_W'(i_cfg.gain_a);
    assign w_pb   = PE_W'(i_last_error) * PE_W'(i_cfg.gain_b);
    assign w_pc   = PC_W'(i_last_output) * PC_W'(i_cfg.pole_c);
    assign w_pc_q = w_pc[PC_W-1:mdc_pkg::Q_SHIFT];

    assign w_prev = (i_cfg.mode == mdc_pkg::MODE_PI) ? SUM_W'(i_last_output)
                                                     : SUM_W'(w_pc_q);
    assign w_sum  = w_prev + SUM_W'(w_pa) - SUM_W'(w_pb);
    assign w_sel  = (i_cfg.mode == mdc_pkg::MODE_P) ? SUM_W'(w_pa) : w_sum;

    // The sum fits the accumulator when its top bits are all copies of the sign.
    assign w_fits = (&w_sel[SUM_W-1:ACC_W-1]) || !(|w_sel[SUM_W-1:ACC_W-1]);
    assign w_acc  = w_fits ? w_sel[ACC_W-1:0]
                           : (w_sel[SUM_W-1] ? ACC_MIN : ACC_MAX);

    assign w_small = w_acc[ACC_W-1] || !(|w_acc[ACC_W-2:LO_B]);
    assign w_big   = |w_acc[ACC_W-2:HI_B];

    always_comb begin
        o_law.error       = w_err;
        o_law.state_wr    = 1'b0;
        o_law.last_output = w_acc;
        o_law.last_error  = w_err;
        o_law.saturated   = !w_fits;
        o_law.duty        = w_acc[HI_B-1:LO_B];
        if (w_small) begin
            o_law.duty      = DUTY_MIN;
            o_law.saturated = 1'b1;
        end else if (w_big) begin
            o_law.duty      = DUTY_MAX;
            o_law.saturated = 1'b1;
        end
        case (i_cfg.mode)
            mdc_pkg::MODE_OPEN: begin
                o_law.duty      = (i_cfg.ol_duty == '0) ? DUTY_MIN : i_cfg.ol_duty;
                o_law.saturated = (i_cfg.ol_duty == '0);
            end
            mdc_pkg::MODE_P: begin
                o_law.state_wr = 1'b0;
            end
            mdc_pkg::MODE_PI, mdc_pkg::MODE_COMP: begin
                o_law.state_wr = 1'b1;
            end
            default: begin
                o_law.state_wr = 1'b0;
            end
        endcase
        // Off clears the history and forces an all-zero result.
        if (i_off) begin
            o_law.duty        = '0;
            o_law.error       = '0;
            o_law.saturated   = 1'b0;
            o_law.state_wr    = 1'b1;
            o_law.last_output = '0;
            o_law.last_error  = '0;
        end
    end

endmodule

// ===== src/multimode_digital_controller.sv =====
// ----------------------------------------------------------------------------
// multimode_digital_controller
// Throughput: one sample per cycle while the output is not stalled; the
// controller history register feeds the pole multiply and saturating sum of
// the next sample. Reset (synchronous, active low) restores the configuration
// registers to their defaults, clears the output history and previous error,
// and empties the pipeline.
// ----------------------------------------------------------------------------
//
// Structure
//   The accepted sample and off flag are captured in an input register. The
//   control law (mdc_law) works between that register and the result
//   register, and on the same edge that loads a result it updates the
//   history (last output, last error) in PI and compensator modes, or clears
//   it when off is set. Because the history is written in order of the
//   transactions, back-to-back samples see exactly the state left by the
//   previous one.
//
// Flow control
//   The pipeline advances whenever the result register is empty or its
//   transaction is being taken. The input side is stalled only while an
//   item is held in the input register and the result register cannot move,
//   so a finished result waiting downstream does not block the next sample
//   from being captured while the input register is empty.
//
// Configuration
//   Writes are taken every cycle and land in mdc_cfg_regs. They are expected
//   only while the controller is idle.
// ----------------------------------------------------------------------------
module multimode_digital_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mdc_pkg::SAMPLE_W-1:0]         i_sample,
    input  logic                                 i_off,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mdc_pkg::DUTY_W-1:0]           o_duty,
    output logic signed [mdc_pkg::ERR_W-1:0]     o_error,
    output logic                                 o_saturated,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    mdc_pkg::t_cfg w_cfg;
    mdc_pkg::t_law w_law;

    // Input register.
    logic                                  r_in_valid;
    logic [mdc_pkg::SAMPLE_W-1:0]          r_in_sample;
    logic                                  r_in_off;

    // Result register.
    logic                                  r_out_valid;
    logic [mdc_pkg::DUTY_W-1:0]            r_out_duty;
    logic signed [mdc_pkg::ERR_W-1:0]      r_out_error;
    logic                                  r_out_sat;

    // Controller history.
    logic signed [mdc_pkg::ACC_WIDTH-1:0]  r_last_output;
    logic signed [mdc_pkg::ERR_W-1:0]      r_last_error;

    logic w_advance;
    logic w_in_take;

    mdc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mdc_law u_law (
        .i_cfg         (w_cfg),
        .i_sample      (r_in_sample),
        .i_off         (r_in_off),
        .i_last_output (r_last_output),
        .i_last_error  (r_last_error),
        .o_law         (w_law)
    );

    // The result register can load when it is empty or being drained.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_out_duty;
    assign o_error     = r_out_error;
    assign o_saturated = r_out_sat;

    // Control state. The input register fills whenever it takes a sample,
    // even while the result register is held, and empties when it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_output <= '0;
            r_last_error  <= '0;
        end else begin
            if (w_advance || w_in_take) begin
                r_in_valid <= w_in_take;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid && w_law.state_wr) begin
                    r_last_output <= w_law.last_output;
                    r_last_error  <= w_law.last_error;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_sample <= i_sample;
            r_in_off    <= i_off;
        end
        if (w_advance && r_in_valid) begin
            r_out_duty  <= w_law.duty;
            r_out_error <= w_law.error;
            r_out_sat   <= w_law.saturated;
        end
    end

    // An off transaction leaves the history cleared.
    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid && r_in_off)
        |=> (r_last_output == '0 && r_last_error == '0))
        else $error("history not cleared after off");

    // Open loop and proportional transactions leave the history alone.
    a_hist_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_valid && !r_in_off
         && (w_cfg.mode == mdc_pkg::MODE_OPEN || w_cfg.mode == mdc_pkg::MODE_P))
        |=> ($stable(r_last_output) && $stable(r_last_error)))
        else $error("history changed in a stateless mode");

    // Zero duty comes only from off, which also zeroes error and flag.
    a_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty == '0) |-> (o_error == '0 && !o_saturated))
        else $error("zero duty without off");

    // The input side stalls only while an item is held.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing pending");

    // Every result loaded comes from an item held in the input register.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> $past(r_in_valid))
        else $error("result without a source item");

endmodule
